FILE: rtl/atrf_pkg.sv
// Shared types and constants for the alarm table range firer.
// Used by atrf_floor and alarm_table_range_firer; no dependencies.
`default_nettype none

package atrf_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    localparam int TIME_W = 28;
    localparam int DATE_W = 27;
    localparam int SEQ_W  = 32;
    localparam int OP_W   = 2;
    localparam int KIND_W = 2;
    localparam int CFG_IDX_W = 2;

    // floor(t / div) * div by reciprocal multiply and one correction step
    localparam int DIV_W       = 17;
    localparam int RECIP_W     = 29;
    localparam int RECIP_SHIFT = 38;
    localparam int PROD_W      = TIME_W + RECIP_W;
    localparam int Q_W         = 19;
    localparam int BASE_W      = Q_W + DIV_W;

    localparam logic [DIV_W-1:0]   SEC_DIV   = DIV_W'(1000);
    localparam logic [DIV_W-1:0]   MIN_DIV   = DIV_W'(100000);
    localparam logic [RECIP_W-1:0] SEC_RECIP = RECIP_W'(274877906);
    localparam logic [RECIP_W-1:0] MIN_RECIP = RECIP_W'(2748779);

    localparam logic [OP_W-1:0] OP_REGISTER   = 2'd0;
    localparam logic [OP_W-1:0] OP_UNREGISTER = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR      = 2'd2;
    localparam logic [OP_W-1:0] OP_ADVANCE    = 2'd3;

    localparam logic [KIND_W-1:0] KIND_FIRE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SECOND = 2'd1;
    localparam logic [KIND_W-1:0] KIND_MINUTE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_DONE   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_EVENT_DATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_EN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MINUTE_EN  = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [TIME_W-1:0] alarm_time;
        logic [TIME_W-1:0] target_time;
    } t_in_item;

    typedef struct packed {
        logic [KIND_W-1:0] event_kind;
        logic [TIME_W-1:0] event_time;
        logic [DATE_W-1:0] date_out;
        logic [SEQ_W-1:0]  sequence_number;
        logic              table_full;
        logic              last_of_run;
    } t_out_item;

endpackage

`default_nettype wire

FILE: rtl/atrf_floor.sv
// Shared rounding unit: rounds a time down to a multiple of 1000 or 100000.
// Pipelined, one multiplier per stage. Depends on atrf_pkg.
`default_nettype none

module atrf_floor
    import atrf_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic              i_sel_minute,
    input  wire logic [TIME_W-1:0] i_value,
    output logic                   o_done,
    output logic [TIME_W-1:0]      o_value
);

    logic              r_v1;
    logic              r_sel;
    logic [TIME_W-1:0] r_t;
    logic [Q_W-1:0]    r_q;
    logic              r_done;
    logic [TIME_W-1:0] r_value;

    logic [RECIP_W-1:0] recip;
    logic [PROD_W-1:0]  prod;
    logic [DIV_W-1:0]   div;
    logic [BASE_W-1:0]  base_full;
    logic [TIME_W-1:0]  base;
    logic [TIME_W-1:0]  rem;
    logic [TIME_W-1:0]  div_t;

    assign recip     = i_sel_minute ? MIN_RECIP : SEC_RECIP;
    assign prod      = PROD_W'(i_value) * PROD_W'(recip);
    assign div       = r_sel ? MIN_DIV : SEC_DIV;
    assign base_full = BASE_W'(r_q) * BASE_W'(div);
    assign base      = base_full[TIME_W-1:0];
    assign rem       = r_t - base;
    assign div_t     = TIME_W'(div);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_v1   <= i_start;
            r_done <= r_v1;
        end
        if (i_start) begin
            r_t   <= i_value;
            r_sel <= i_sel_minute;
            r_q   <= prod[RECIP_SHIFT +: Q_W];
        end
        if (r_v1) begin
            r_value <= (rem >= div_t) ? base + div_t : base;
        end
    end

    assign o_done  = r_done;
    assign o_value = r_value;

endmodule

`default_nettype wire

FILE: rtl/alarm_table_range_firer.sv
// Alarm table range firer, top level. Holds the alarm table and sequencer.
// Depends on atrf_pkg and atrf_floor.
`default_nettype none

// One item at a time: start is taken while busy is low. busy stays high until
// the item's done result goes out, and is already low in the cycle that shows
// it, so the next item can be taken at the edge that ends that cycle.
// Results come one per strobe cycle on o_result and must be taken when shown;
// nothing holds them off. Clear goes straight to the done state. Register and
// unregister make one pass over the table, one slot per cycle through a single
// comparator, then apply the change. An advance firing k alarms makes k + 1
// passes over the table, each ending in an evaluation step; each firing adds a
// fire step and, for each enabled boundary kind, a trip through the shared
// two-stage rounding multiplier. The run ends with the done state and the done
// result.

module alarm_table_range_firer
    import atrf_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire t_in_item             i_item,
    output logic                      o_result_valid,
    output t_out_item                 o_result,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [DATE_W-1:0]    i_cfg_wdata
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY,
        S_EVAL,
        S_RND,
        S_RND_WAIT,
        S_FIRE,
        S_DONE
    } t_state;

    t_state r_state;

    logic [DATE_W-1:0] r_event_date;
    logic              r_sec_en;
    logic              r_min_en;

    logic [TIME_W-1:0]      r_slots [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] r_valid;

    logic [TIME_W-1:0] r_current;
    logic [TIME_W-1:0] r_sec_mark;
    logic [TIME_W-1:0] r_min_mark;
    logic [SEQ_W-1:0]  r_fired;

    logic [OP_W-1:0]   r_op;
    logic [TIME_W-1:0] r_alarm;
    logic [TIME_W-1:0] r_target;
    logic [TIME_W-1:0] r_prev;
    logic [IDX_W-1:0]  r_idx;
    logic              r_hit;
    logic [IDX_W-1:0]  r_hit_idx;
    logic              r_free_found;
    logic [IDX_W-1:0]  r_free_idx;
    logic              r_found;
    logic [TIME_W-1:0] r_best;
    logic              r_full;
    logic              r_rnd_min;

    logic              r_out_valid;
    t_out_item         r_out;

    logic [TIME_W-1:0] slot_t;
    logic              slot_v;
    logic              last_idx;
    logic              adv_take;
    logic              slot_write;
    logic              rnd_start;
    logic              rnd_done;
    logic [TIME_W-1:0] rnd_value;

    function automatic t_out_item make_out(
        input logic [KIND_W-1:0] kind,
        input logic [TIME_W-1:0] t,
        input logic [DATE_W-1:0] date,
        input logic [SEQ_W-1:0]  seq,
        input logic              full,
        input logic              last
    );
        t_out_item o;
        o.event_kind      = kind;
        o.event_time      = t;
        o.date_out        = date;
        o.sequence_number = seq;
        o.table_full      = full;
        o.last_of_run     = last;
        return o;
    endfunction

    assign slot_t   = r_slots[r_idx];
    assign slot_v   = r_valid[r_idx];
    assign last_idx = (r_idx == IDX_W'(TABLE_DEPTH - 1));
    assign adv_take = slot_v && (slot_t > r_prev) && (slot_t <= r_target) &&
                      (!r_found || (slot_t < r_best));

    assign slot_write = (r_state == S_APPLY) && (r_op == OP_REGISTER) &&
                        !r_hit && r_free_found;
    assign rnd_start  = (r_state == S_RND);

    atrf_floor u_floor (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (rnd_start),
        .i_sel_minute (r_rnd_min),
        .i_value      (r_best),
        .o_done       (rnd_done),
        .o_value      (rnd_value)
    );

    always_ff @(posedge i_clk) begin
        if (slot_write) begin
            r_slots[r_free_idx] <= r_alarm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_event_date <= '0;
            r_sec_en     <= 1'b0;
            r_min_en     <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_EVENT_DATE: r_event_date <= i_cfg_wdata;
                CFG_SECOND_EN:  r_sec_en     <= i_cfg_wdata[0];
                CFG_MINUTE_EN:  r_min_en     <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_current   <= '0;
            r_sec_mark  <= '0;
            r_min_mark  <= '0;
            r_fired     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_op         <= i_item.operation;
                        r_alarm      <= i_item.alarm_time;
                        r_target     <= i_item.target_time;
                        r_prev       <= r_current;
                        r_idx        <= '0;
                        r_hit        <= 1'b0;
                        r_free_found <= 1'b0;
                        r_found      <= 1'b0;
                        r_full       <= 1'b0;
                        if (i_item.operation == OP_CLEAR) begin
                            r_valid <= '0;
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (r_op == OP_ADVANCE) begin
                        if (adv_take) begin
                            r_found <= 1'b1;
                            r_best  <= slot_t;
                        end
                    end else begin
                        if (slot_v && (slot_t == r_alarm) && !r_hit) begin
                            r_hit     <= 1'b1;
                            r_hit_idx <= r_idx;
                        end
                        if (!slot_v && !r_free_found) begin
                            r_free_found <= 1'b1;
                            r_free_idx   <= r_idx;
                        end
                    end
                    r_idx <= r_idx + 1'b1;
                    if (last_idx) begin
                        r_state <= (r_op == OP_ADVANCE) ? S_EVAL : S_APPLY;
                    end
                end
                S_APPLY: begin
                    case (r_op)
                        OP_REGISTER: begin
                            if (!r_hit) begin
                                if (r_free_found) begin
                                    r_valid[r_free_idx] <= 1'b1;
                                end else begin
                                    r_full <= 1'b1;
                                end
                            end
                        end
                        OP_UNREGISTER: begin
                            if (r_hit) begin
                                r_valid[r_hit_idx] <= 1'b0;
                            end
                        end
                        default: ;
                    endcase
                    r_state <= S_DONE;
                end
                S_EVAL: begin
                    if (!r_found) begin
                        r_current <= r_target;
                        r_state   <= S_DONE;
                    end else if (r_sec_en) begin
                        r_rnd_min <= 1'b0;
                        r_state   <= S_RND;
                    end else if (r_min_en) begin
                        r_rnd_min <= 1'b1;
                        r_state   <= S_RND;
                    end else begin
                        r_state <= S_FIRE;
                    end
                end
                S_RND: begin
                    r_state <= S_RND_WAIT;
                end
                S_RND_WAIT: begin
                    if (rnd_done) begin
                        if (!r_rnd_min) begin
                            if (rnd_value != r_sec_mark) begin
                                r_sec_mark  <= rnd_value;
                                r_out_valid <= 1'b1;
                                r_out <= make_out(KIND_SECOND, rnd_value, r_event_date,
                                                  r_fired, 1'b0, 1'b0);
                            end
                            if (r_min_en) begin
                                r_rnd_min <= 1'b1;
                                r_state   <= S_RND;
                            end else begin
                                r_state <= S_FIRE;
                            end
                        end else begin
                            if (rnd_value != r_min_mark) begin
                                r_min_mark  <= rnd_value;
                                r_out_valid <= 1'b1;
                                r_out <= make_out(KIND_MINUTE, rnd_value, r_event_date,
                                                  r_fired, 1'b0, 1'b0);
                            end
                            r_state <= S_FIRE;
                        end
                    end
                end
                S_FIRE: begin
                    r_fired     <= r_fired + 1'b1;
                    r_out_valid <= 1'b1;
                    r_out <= make_out(KIND_FIRE, r_best, r_event_date,
                                      r_fired + 1'b1, 1'b0, 1'b0);
                    r_prev  <= r_best;
                    r_found <= 1'b0;
                    r_idx   <= '0;
                    r_state <= S_SCAN;
                end
                S_DONE: begin
                    r_out_valid <= 1'b1;
                    r_out <= make_out(KIND_DONE, r_current, r_event_date,
                                      r_fired, r_full, 1'b1);
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy           = (r_state != S_IDLE);
    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

endmodule

`default_nettype wire

FILE: bench/tb_alarm_table_range_firer.sv
// Self-checking testbench for alarm_table_range_firer: directed rows, then random phases
// under several date/enable settings, every result checked against an in-bench predictor.
// Depends on atrf_pkg and the RTL of alarm_table_range_firer.
`timescale 1ns / 100ps

module tb_alarm_table_range_firer;
    import atrf_pkg::*;

    localparam int          RESET_CYCLES = 6;
    localparam int          CYCLE_LIMIT  = 1000000;
    localparam int          PHASE_ITEMS  = 80;
    localparam int          PHASES       = 5;
    localparam int          DIR_ROWS     = 24;
    localparam int unsigned SEC_UNIT     = 1000;
    localparam int unsigned MIN_UNIT     = 100000;
    localparam int unsigned WINDOW       = 1000000;
    localparam logic [DATE_W-1:0]    DIR_DATE  = DATE_W'(99991231);
    localparam logic [TIME_W-1:0]    TIME_MAX  = '1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start = 1'b0;
    logic      busy;
    t_in_item  i_item = '0;
    logic      o_result_valid;
    t_out_item o_result;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [DATE_W-1:0]    i_cfg_wdata = '0;

    alarm_table_range_firer dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (i_item),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // predictor state
    logic [TIME_W-1:0] tbl_time [TABLE_DEPTH];
    bit                tbl_used [TABLE_DEPTH];
    logic [TIME_W-1:0] clock_now = '0;
    logic [TIME_W-1:0] sec_mark = '0;
    logic [TIME_W-1:0] min_mark = '0;
    logic [SEQ_W-1:0]  fired_total = '0;
    logic [DATE_W-1:0] cur_date = '0;
    bit                cur_sec_en = 1'b0;
    bit                cur_min_en = 1'b0;

    t_out_item expected_events [$];
    int        mismatches = 0;
    int        cycle_count = 0;

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [TIME_W-1:0] alarm;
        logic [TIME_W-1:0] target;
        int                run_len;
        bit                typed;
        logic [TIME_W-1:0] done_time;
        logic [SEQ_W-1:0]  done_seq;
        bit                done_full;
    } t_dir_row;

    // run_len > 1 registers alarm, alarm+1, ...; typed rows carry the done result
    t_dir_row dir_rows [DIR_ROWS] = '{
        '{OP_REGISTER,   28'd0,         TIME_MAX,      1, 1'b1, 28'd0,    32'd0, 1'b0},
        '{OP_REGISTER,   TIME_MAX,      28'd0,         1, 1'b1, 28'd0,    32'd0, 1'b0},
        '{OP_REGISTER,   28'd999,       28'd0,         1, 1'b0, 28'd0,    32'd0, 1'b0},
        '{OP_REGISTER,   28'd1500,      28'd0,         1, 1'b0, 28'd0,    32'd0, 1'b0},
        '{OP_REGISTER,   28'd99999,     28'd0,         1, 1'b0, 28'd0,    32'd0, 1'b0},
        '{OP_REGISTER,   28'd1500,      28'd0,         1, 1'b1, 28'd0,    32'd0, 1'b0},
        '{OP_REGISTER,   28'd235959999, 28'd0,         1, 1'b0, 28'd0,    32'd0, 1'b0},
        '{OP_UNREGISTER, 28'd777,       28'd0,         1, 1'b1, 28'd0,    32'd0, 1'b0},
        '{OP_ADVANCE,    28'd0,         28'd0,         1, 1'b1, 28'd0,    32'd0, 1'b0},
        '{OP_ADVANCE,    28'd0,         28'd100000,    1, 1'b0, 28'd0,    32'd0, 1'b0},
        '{OP_ADVANCE,    28'd0,         28'd235959999, 1, 1'b0, 28'd0,    32'd0, 1'b0},
        '{OP_ADVANCE,    28'd0,         28'd500,       1, 1'b0, 28'd0,    32'd0, 1'b0},
        '{OP_UNREGISTER, 28'd1500,      28'd0,         1, 1'b0, 28'd0,    32'd0, 1'b0},
        '{OP_ADVANCE,    28'd0,         TIME_MAX,      1, 1'b0, 28'd0,    32'd0, 1'b0},
        '{OP_CLEAR,      TIME_MAX,      TIME_MAX,      1, 1'b0, 28'd0,    32'd0, 1'b0},
        '{OP_REGISTER,   28'd12000000,  28'd0,         TABLE_DEPTH,
                                                          1'b0, 28'd0,    32'd0, 1'b0},
        '{OP_REGISTER,   28'd13000000,  28'd0,         1, 1'b1, TIME_MAX, 32'd8, 1'b1},
        '{OP_ADVANCE,    28'd0,         28'd0,         1, 1'b0, 28'd0,    32'd0, 1'b0},
        '{OP_ADVANCE,    28'd0,         28'd12000010,  1, 1'b0, 28'd0,    32'd0, 1'b0},
        '{OP_UNREGISTER, 28'd12000005,  28'd0,         1, 1'b0, 28'd0,    32'd0, 1'b0},
        '{OP_REGISTER,   28'd13000000,  28'd0,         1, 1'b0, 28'd0,    32'd0, 1'b0},
        '{OP_ADVANCE,    28'd0,         TIME_MAX,      1, 1'b0, 28'd0,    32'd0, 1'b0},
        '{OP_CLEAR,      28'd0,         28'd0,         1, 1'b0, 28'd0,    32'd0, 1'b0},
        '{OP_ADVANCE,    28'd0,         28'd0,         1, 1'b0, 28'd0,    32'd0, 1'b0}
    };

    function automatic t_out_item make_result(logic [KIND_W-1:0] kind, logic [TIME_W-1:0] t,
                                              logic [SEQ_W-1:0] seq, bit full, bit last);
        t_out_item r;
        r.event_kind      = kind;
        r.event_time      = t;
        r.date_out        = cur_date;
        r.sequence_number = seq;
        r.table_full      = full;
        r.last_of_run     = last;
        return r;
    endfunction

    task automatic predict_events(input t_in_item it);
        int                hit;
        int                free_slot;
        int                best;
        bit                full;
        logic [TIME_W-1:0] prev;
        logic [TIME_W-1:0] t;
        logic [TIME_W-1:0] mark;
        hit = -1;
        free_slot = -1;
        full = 1'b0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (hit < 0 && tbl_used[i] && tbl_time[i] == it.alarm_time) hit = i;
            if (free_slot < 0 && !tbl_used[i]) free_slot = i;
        end
        case (it.operation)
            OP_REGISTER: begin
                if (hit < 0) begin
                    if (free_slot < 0) begin
                        full = 1'b1;
                    end else begin
                        tbl_time[free_slot] = it.alarm_time;
                        tbl_used[free_slot] = 1'b1;
                    end
                end
            end
            OP_UNREGISTER: begin
                if (hit >= 0) tbl_used[hit] = 1'b0;
            end
            OP_CLEAR: begin
                for (int i = 0; i < TABLE_DEPTH; i++) tbl_used[i] = 1'b0;
            end
            OP_ADVANCE: begin
                prev = clock_now;
                while (1) begin
                    best = -1;
                    for (int i = 0; i < TABLE_DEPTH; i++) begin
                        if (tbl_used[i] && tbl_time[i] > prev && tbl_time[i] <= it.target_time
                            && (best < 0 || tbl_time[i] < tbl_time[best]))
                            best = i;
                    end
                    if (best < 0) break;
                    t = tbl_time[best];
                    if (cur_sec_en) begin
                        mark = TIME_W'((32'(t) / SEC_UNIT) * SEC_UNIT);
                        if (mark != sec_mark) begin
                            expected_events.push_back(
                                make_result(KIND_SECOND, mark, fired_total, 1'b0, 1'b0));
                            sec_mark = mark;
                        end
                    end
                    if (cur_min_en) begin
                        mark = TIME_W'((32'(t) / MIN_UNIT) * MIN_UNIT);
                        if (mark != min_mark) begin
                            expected_events.push_back(
                                make_result(KIND_MINUTE, mark, fired_total, 1'b0, 1'b0));
                            min_mark = mark;
                        end
                    end
                    fired_total = fired_total + 1'b1;
                    expected_events.push_back(make_result(KIND_FIRE, t, fired_total, 1'b0, 1'b0));
                    prev = t;
                end
                clock_now = it.target_time;
            end
        endcase
        expected_events.push_back(make_result(KIND_DONE, clock_now, fired_total, full, 1'b1));
    endtask

    task automatic check_field(string name, logic [SEQ_W-1:0] want, logic [SEQ_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_result_valid) begin
            if (expected_events.size() == 0) begin
                $error("unexpected result: kind %0d time %0d", o_result.event_kind,
                       o_result.event_time);
                mismatches++;
            end else begin
                want = expected_events.pop_front();
                check_field("event_kind", want.event_kind, o_result.event_kind);
                check_field("event_time", want.event_time, o_result.event_time);
                check_field("date_out", want.date_out, o_result.date_out);
                check_field("sequence_number", want.sequence_number, o_result.sequence_number);
                check_field("table_full", want.table_full, o_result.table_full);
                check_field("last_of_run", want.last_of_run, o_result.last_of_run);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("alarm_table_range_firer test failed");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATE_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        case (idx)
            CFG_EVENT_DATE: cur_date = data;
            CFG_SECOND_EN:  cur_sec_en = data[0];
            CFG_MINUTE_EN:  cur_min_en = data[0];
            default: ;
        endcase
    endtask

    task automatic apply_setting(logic [DATE_W-1:0] date, bit sec_en, bit min_en);
        logic [DATE_W-1:0] d;
        write_reg(CFG_EVENT_DATE, date);
        d = DATE_W'($urandom);
        d[0] = sec_en;
        write_reg(CFG_SECOND_EN, d);
        d = DATE_W'($urandom);
        d[0] = min_en;
        write_reg(CFG_MINUTE_EN, d);
        write_reg(CFG_SPARE, DATE_W'($urandom));
        i_cfg_we <= 1'b0;
    endtask

    // returns at the edge that takes the item, with the prediction done
    task automatic offer_item(input t_in_item it);
        i_item <= it;
        start  <= 1'b1;
        do @(posedge i_clk); while (busy);
        predict_events(it);
    endtask

    task automatic idle(int unsigned n);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 4);
        return $urandom_range(10, 200);
    endfunction

    task automatic wait_idle();
        while (expected_events.size() != 0 || busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic bit pick_stored(output logic [TIME_W-1:0] val);
        int idx [$];
        val = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
            if (tbl_used[i]) idx.push_back(i);
        if (idx.size() == 0) return 1'b0;
        val = tbl_time[idx[$urandom_range(idx.size() - 1)]];
        return 1'b1;
    endfunction

    task automatic pick_random_item(output t_in_item it);
        int unsigned       r;
        logic [TIME_W-1:0] t;
        r = $urandom_range(99);
        it.alarm_time  = TIME_W'($urandom_range(0, WINDOW));
        it.target_time = TIME_W'($urandom);
        if (r < 40) begin
            it.operation = OP_REGISTER;
            r = $urandom_range(99);
            if (r < 15 && pick_stored(t)) it.alarm_time = t;
            else if (r < 25) it.alarm_time = TIME_W'($urandom);
            else if (r < 35) it.alarm_time = TIME_W'($urandom_range(0, 1200));
        end else if (r < 54) begin
            it.operation = OP_UNREGISTER;
            if ($urandom_range(99) < 70 && pick_stored(t)) it.alarm_time = t;
        end else if (r < 60) begin
            it.operation = OP_CLEAR;
            it.alarm_time = TIME_W'($urandom);
        end else begin
            it.operation = OP_ADVANCE;
            r = $urandom_range(99);
            if (r < 8) it.target_time = TIME_W'($urandom);
            else if (r < 10) it.target_time = TIME_MAX;
            else if (clock_now > WINDOW || r < 30)
                it.target_time = TIME_W'($urandom_range(0, WINDOW / 4));
            else it.target_time = clock_now + TIME_W'($urandom_range(0, 300000));
        end
    endtask

    initial begin
        t_in_item    it;
        int unsigned gap;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            tbl_time[i] = '0;
            tbl_used[i] = 1'b0;
        end
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        apply_setting(DIR_DATE, 1'b1, 1'b1);
        foreach (dir_rows[n]) begin
            for (int k = 0; k < dir_rows[n].run_len; k++) begin
                it.operation   = dir_rows[n].op;
                it.alarm_time  = dir_rows[n].alarm + TIME_W'(k);
                it.target_time = dir_rows[n].target;
                offer_item(it);
                if (dir_rows[n].typed)
                    expected_events[$] = '{KIND_DONE, dir_rows[n].done_time, DIR_DATE,
                                           dir_rows[n].done_seq, dir_rows[n].done_full, 1'b1};
                gap = pick_gap();
                if (n == DIR_ROWS - 1 && gap == 0) gap = 1;
                idle(gap);
            end
        end
        wait_idle();

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: apply_setting('0, 1'b0, 1'b0);
                1: apply_setting('1, 1'b1, 1'b0);
                2: apply_setting(DATE_W'($urandom_range(0, 99991231)), 1'b0, 1'b1);
                3: apply_setting(DATE_W'($urandom_range(0, 99991231)), 1'b1, 1'b1);
                default: apply_setting(DIR_DATE, 1'b1, 1'b1);
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick_random_item(it);
                offer_item(it);
                gap = (n >= 20 && n < 40) ? 0 : pick_gap();
                if (n == PHASE_ITEMS - 1 && gap == 0) gap = 1;
                idle(gap);
            end
            wait_idle();
        end

        repeat (TABLE_DEPTH * 4) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("alarm_table_range_firer test passed");
        end else begin
            $display("alarm_table_range_firer test failed");
        end
        $finish;
    end

endmodule
